// File: rtl/core/ifpp_pkg.sv
// Shared types and constants of the sensor-hub FIFO packet parser.
`default_nettype none
package ifpp_pkg;

   // Fixed packet ids
   localparam logic [7:0] ID_PADDING    = 8'h00;
   localparam logic [7:0] ID_TS_DELTA_S = 8'hFA;
   localparam logic [7:0] ID_TS_DELTA_L = 8'hFB;
   localparam logic [7:0] ID_TS_FULL    = 8'hFC;
   localparam logic [7:0] ID_META       = 8'hFD;
   localparam logic [7:0] ID_META_WAKE  = 8'hFE;

   // Payload lengths in bytes
   localparam logic [2:0] LEN_SAMPLE = 3'd6;
   localparam logic [2:0] LEN_DELTA  = 3'd1;
   localparam logic [2:0] LEN_LONG   = 3'd3;

   // Result kinds
   localparam logic [1:0] KIND_ACCEL = 2'd0;
   localparam logic [1:0] KIND_GYRO  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Stop causes
   localparam logic [1:0] STOP_CLEAN   = 2'd0;
   localparam logic [1:0] STOP_PADDING = 2'd1;
   localparam logic [1:0] STOP_UNKNOWN = 2'd2;
   localparam logic [1:0] STOP_TRUNC   = 2'd3;

   // Configuration register indexes
   localparam logic CSR_ACCEL_ID = 1'b0;
   localparam logic CSR_GYRO_ID  = 1'b1;

   localparam logic [7:0] ACCEL_ID_RESET = 8'd1;
   localparam logic [7:0] GYRO_ID_RESET  = 8'd10;

   // Result queue depth; two free slots are needed to take a byte
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      PH_ID      = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_HALT    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CLASS_ACCEL = 2'd0,
      CLASS_GYRO  = 2'd1,
      CLASS_SKIP  = 2'd2
   } class_type;

   typedef struct packed {
      logic [1:0]        report_kind;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic              accel_seen;
      logic [1:0]        stop_cause;
      logic              run_last;
   } result_type;

   // Results produced by one accepted byte, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage
`default_nettype wire

// File: rtl/core/ifpp_req_if.sv
// Byte input channel of the packet parser.
`default_nettype none
interface ifpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ifpp_rsp_if.sv
// Result channel of the packet parser.
`default_nettype none
interface ifpp_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        report_kind;
   logic signed [15:0] axis_x;
   logic signed [15:0] axis_y;
   logic signed [15:0] axis_z;
   logic              accel_seen;
   logic [1:0]        stop_cause;
   logic              run_last;

   modport source (output valid, output report_kind, output axis_x, output axis_y,
                   output axis_z, output accel_seen, output stop_cause, output run_last,
                   input ready);
   modport sink (input valid, input report_kind, input axis_x, input axis_y,
                 input axis_z, input accel_seen, input stop_cause, input run_last,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/core/imu_fifo_packet_parser_top.sv
// Top level of the sensor-hub FIFO packet parser.
//
// req_chan carries drained FIFO bytes, one per beat, with buffer_end on the
// last byte of each buffer. rsp_chan carries results: accel or gyro samples
// (three signed axes) and one end-of-buffer report per buffer with the
// accel-seen flag and the stop cause. csr_* writes the accel and gyro packet
// ids (index 0 and 1); write them only while the block is idle.
// Latency: with the queue empty, the first result of a byte appears on
// rsp_chan the cycle after the byte is taken. Throughput: one byte per cycle
// while req_chan.ready is high; a byte decodes in combinational logic and
// its results go into a four-entry result queue. A byte that ends a sample
// on the buffer end causes two results. Queued results drain one per cycle
// while rsp_chan is ready. req_chan.ready is high while the queue has two
// free entries; with rsp_chan always ready the queue never holds more than
// two, so it drops only when the receiver stalls rsp_chan.
// Reset (synchronous): parser rearms for a new buffer, queue empties, the
// ids return to 1 (accel) and 10 (gyro).
`default_nettype none
module imu_fifo_packet_parser_top (
   input  wire logic       clock,
   input  wire logic       reset,
   ifpp_req_if.sink        req_chan,
   ifpp_rsp_if.source      rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wr_data
);

   logic [7:0]           accel_id_ff;
   logic [7:0]           gyro_id_ff;
   logic                 room;
   logic                 accept;
   ifpp_pkg::push_type   push;
   ifpp_pkg::result_type head;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid & room;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_id_ff <= ifpp_pkg::ACCEL_ID_RESET;
         gyro_id_ff  <= ifpp_pkg::GYRO_ID_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ifpp_pkg::CSR_ACCEL_ID: accel_id_ff <= csr_wr_data;
            ifpp_pkg::CSR_GYRO_ID:  gyro_id_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   ifpp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_chan.data_byte),
      .buffer_end (req_chan.buffer_end),
      .accel_id   (accel_id_ff),
      .gyro_id    (gyro_id_ff),
      .push       (push)
   );

   ifpp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (head)
   );

   assign rsp_chan.report_kind = head.report_kind;
   assign rsp_chan.axis_x      = head.axis_x;
   assign rsp_chan.axis_y      = head.axis_y;
   assign rsp_chan.axis_z      = head.axis_z;
   assign rsp_chan.accel_seen  = head.accel_seen;
   assign rsp_chan.stop_cause  = head.stop_cause;
   assign rsp_chan.run_last    = head.run_last;

endmodule
`default_nettype wire

// File: rtl/core/ifpp_parser.sv
// Per-byte packet decode: parse state and the results each byte causes.
`default_nettype none
module ifpp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              buffer_end,
   input  wire logic [7:0]        accel_id,
   input  wire logic [7:0]        gyro_id,
   output ifpp_pkg::push_type     push
);

   ifpp_pkg::phase_type phase_ff, phase_in;
   ifpp_pkg::class_type class_ff, class_in;
   logic [2:0]  left_ff, left_in;
   logic [39:0] shift_ff, shift_in;
   logic        accel_ff, accel_in;
   logic [1:0]  cause_ff, cause_in;

   ifpp_pkg::result_type sample;
   ifpp_pkg::result_type end_rep;
   logic                 sample_hit;

   always_comb begin
      phase_in   = phase_ff;
      class_in   = class_ff;
      left_in    = left_ff;
      shift_in   = shift_ff;
      accel_in   = accel_ff;
      cause_in   = cause_ff;
      sample_hit = 1'b0;
      sample     = '0;
      end_rep    = '0;
      push       = '0;

      if (accept) begin
         unique case (phase_ff)
            ifpp_pkg::PH_ID: begin
               // padding, then configured ids, then fixed; accel beats gyro
               priority if (data_byte == ifpp_pkg::ID_PADDING) begin
                  phase_in = ifpp_pkg::PH_HALT;
                  cause_in = ifpp_pkg::STOP_PADDING;
               end else if (data_byte == accel_id || data_byte == gyro_id) begin
                  class_in = (data_byte == accel_id) ? ifpp_pkg::CLASS_ACCEL
                                                     : ifpp_pkg::CLASS_GYRO;
                  left_in  = ifpp_pkg::LEN_SAMPLE;
                  shift_in = '0;
                  phase_in = ifpp_pkg::PH_PAYLOAD;
               end else if (data_byte == ifpp_pkg::ID_TS_DELTA_S ||
                            data_byte == ifpp_pkg::ID_TS_DELTA_L) begin
                  class_in = ifpp_pkg::CLASS_SKIP;
                  left_in  = ifpp_pkg::LEN_DELTA;
                  phase_in = ifpp_pkg::PH_PAYLOAD;
               end else if (data_byte == ifpp_pkg::ID_TS_FULL ||
                            data_byte == ifpp_pkg::ID_META ||
                            data_byte == ifpp_pkg::ID_META_WAKE) begin
                  class_in = ifpp_pkg::CLASS_SKIP;
                  left_in  = ifpp_pkg::LEN_LONG;
                  phase_in = ifpp_pkg::PH_PAYLOAD;
               end else begin
                  phase_in = ifpp_pkg::PH_HALT;
                  cause_in = ifpp_pkg::STOP_UNKNOWN;
               end
            end
            ifpp_pkg::PH_PAYLOAD: begin
               if (class_ff != ifpp_pkg::CLASS_SKIP) begin
                  unique case (left_ff)
                     3'd6:    shift_in[7:0]   = data_byte;
                     3'd5:    shift_in[15:8]  = data_byte;
                     3'd4:    shift_in[23:16] = data_byte;
                     3'd3:    shift_in[31:24] = data_byte;
                     3'd2:    shift_in[39:32] = data_byte;
                     default: ;
                  endcase
               end
               left_in = left_ff - 3'd1;
               if (left_in == 3'd0) begin
                  phase_in = ifpp_pkg::PH_ID;
                  if (class_ff != ifpp_pkg::CLASS_SKIP) begin
                     sample_hit         = 1'b1;
                     sample.report_kind = (class_ff == ifpp_pkg::CLASS_GYRO)
                                          ? ifpp_pkg::KIND_GYRO : ifpp_pkg::KIND_ACCEL;
                     sample.axis_x      = shift_ff[15:0];
                     sample.axis_y      = shift_ff[31:16];
                     sample.axis_z      = {data_byte, shift_ff[39:32]};
                     sample.run_last    = ~buffer_end;
                     if (class_ff == ifpp_pkg::CLASS_ACCEL) begin
                        accel_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
               phase_in = ifpp_pkg::PH_HALT;
            end
         endcase

         if (buffer_end) begin
            end_rep.report_kind = ifpp_pkg::KIND_END;
            end_rep.accel_seen  = accel_in;
            end_rep.stop_cause  = (phase_in == ifpp_pkg::PH_PAYLOAD)
                                  ? ifpp_pkg::STOP_TRUNC : cause_in;
            end_rep.run_last    = 1'b1;
            phase_in = ifpp_pkg::PH_ID;
            class_in = ifpp_pkg::CLASS_ACCEL;
            left_in  = '0;
            shift_in = '0;
            accel_in = 1'b0;
            cause_in = ifpp_pkg::STOP_CLEAN;
         end

         // sample first, end report behind it
         if (sample_hit) begin
            push.first  = sample;
            push.second = end_rep;
            push.count  = buffer_end ? 2'd2 : 2'd1;
         end else begin
            push.first  = end_rep;
            push.count  = buffer_end ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ifpp_pkg::PH_ID;
         class_ff <= ifpp_pkg::CLASS_ACCEL;
         left_ff  <= '0;
         shift_ff <= '0;
         accel_ff <= 1'b0;
         cause_ff <= ifpp_pkg::STOP_CLEAN;
      end else begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         left_ff  <= left_in;
         shift_ff <= shift_in;
         accel_ff <= accel_in;
         cause_ff <= cause_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/ifpp_result_queue.sv
// Small result queue: takes up to two results a cycle, hands out one while out_ready is high.
`default_nettype none
module ifpp_result_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ifpp_pkg::push_type   push,
   output logic                      room,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output ifpp_pkg::result_type      out_data
);

   localparam int PTR_W   = $clog2(ifpp_pkg::QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(ifpp_pkg::QUEUE_DEPTH + 1);

   ifpp_pkg::result_type slot_ff [ifpp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pop;
   logic [PTR_W-1:0]   wr_next;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign pop       = out_valid & out_ready;
   // a byte may cause two results
   assign room      = (count_ff <= COUNT_W'(ifpp_pkg::QUEUE_DEPTH - 2));
   assign wr_next   = wr_ff + PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + PTR_W'(push.count);
      rd_in    = rd_ff + PTR_W'(pop);
      count_in = count_ff + COUNT_W'(push.count) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/imu_fifo_packet_parser_checker.sv
// Result checker: mirrors the parser state, predicts every result and compares.
module imu_fifo_packet_parser_checker (
   input  logic       clock,
   input  logic       reset,
   ifpp_req_if        req_mon,
   ifpp_rsp_if        rsp_mon,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wr_data,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ifpp_pkg::*;

   phase_type  phase;
   class_type  pclass;
   logic [2:0] left;
   logic [39:0] shift;
   logic       accel_flag;
   logic [1:0] halt_cause;
   logic [7:0] accel_id;
   logic [7:0] gyro_id;
   result_type due_results[$];
   int         errors;

   task automatic rearm();
      phase = PH_ID;
      pclass = CLASS_ACCEL;
      left = '0;
      shift = '0;
      accel_flag = 1'b0;
      halt_cause = STOP_CLEAN;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      result_type r;
      int idx;
      case (phase)
         PH_ID: begin
            if (b == ID_PADDING) begin
               phase = PH_HALT;
               halt_cause = STOP_PADDING;
            end else if (b == accel_id || b == gyro_id) begin
               // accel wins when both ids match
               pclass = (b == accel_id) ? CLASS_ACCEL : CLASS_GYRO;
               left = LEN_SAMPLE;
               shift = '0;
               phase = PH_PAYLOAD;
            end else if (b == ID_TS_DELTA_S || b == ID_TS_DELTA_L) begin
               pclass = CLASS_SKIP;
               left = LEN_DELTA;
               phase = PH_PAYLOAD;
            end else if (b == ID_TS_FULL || b == ID_META || b == ID_META_WAKE) begin
               pclass = CLASS_SKIP;
               left = LEN_LONG;
               phase = PH_PAYLOAD;
            end else begin
               phase = PH_HALT;
               halt_cause = STOP_UNKNOWN;
            end
         end
         PH_PAYLOAD: begin
            if (pclass != CLASS_SKIP && left > 3'd1) begin
               idx = 6 - int'(left);
               shift = shift | (40'(b) << (8 * idx));
            end
            left = left - 3'd1;
            if (left == 3'd0) begin
               phase = PH_ID;
               if (pclass != CLASS_SKIP) begin
                  r = '0;
                  r.report_kind = (pclass == CLASS_ACCEL) ? KIND_ACCEL : KIND_GYRO;
                  r.axis_x = shift[15:0];
                  r.axis_y = shift[31:16];
                  r.axis_z = {b, shift[39:32]};
                  r.run_last = !last;
                  due_results.push_back(r);
                  if (pclass == CLASS_ACCEL) accel_flag = 1'b1;
               end
            end
         end
         default: phase = PH_HALT;
      endcase
      if (last) begin
         r = '0;
         r.report_kind = KIND_END;
         r.accel_seen = accel_flag;
         r.stop_cause = (phase == PH_PAYLOAD) ? STOP_TRUNC : halt_cause;
         r.run_last = 1'b1;
         due_results.push_back(r);
         rearm();
      end
   endtask

   task automatic check_result();
      result_type seen;
      result_type want;
      seen.report_kind = rsp_mon.report_kind;
      seen.axis_x = rsp_mon.axis_x;
      seen.axis_y = rsp_mon.axis_y;
      seen.axis_z = rsp_mon.axis_z;
      seen.accel_seen = rsp_mon.accel_seen;
      seen.stop_cause = rsp_mon.stop_cause;
      seen.run_last = rsp_mon.run_last;
      if (due_results.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected beat: kind %0d axes %0d %0d %0d seen %0d cause %0d last %0d",
                     $realtime, seen.report_kind, seen.axis_x, seen.axis_y, seen.axis_z,
                     seen.accel_seen, seen.stop_cause, seen.run_last);
      end else begin
         want = due_results.pop_front();
         if (seen.report_kind !== want.report_kind || seen.axis_x !== want.axis_x ||
             seen.axis_y !== want.axis_y || seen.axis_z !== want.axis_z ||
             seen.accel_seen !== want.accel_seen || seen.stop_cause !== want.stop_cause ||
             seen.run_last !== want.run_last) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: mismatch: exp kind %0d axes %0d %0d %0d seen %0d cause %0d last %0d",
                        $realtime, want.report_kind, want.axis_x, want.axis_y, want.axis_z,
                        want.accel_seen, want.stop_cause, want.run_last);
               $display("%0t:           got kind %0d axes %0d %0d %0d seen %0d cause %0d last %0d",
                        $realtime, seen.report_kind, seen.axis_x, seen.axis_y, seen.axis_z,
                        seen.accel_seen, seen.stop_cause, seen.run_last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rearm();
         accel_id = ACCEL_ID_RESET;
         gyro_id = GYRO_ID_RESET;
         due_results.delete();
         errors = 0;
      end else begin
         // results leave after their byte's cycle, so pops go before pushes
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) decode_byte(req_mon.data_byte, req_mon.buffer_end);
         if (csr_wr_en) begin
            if (csr_index == CSR_ACCEL_ID) accel_id = csr_wr_data;
            else gyro_id = csr_wr_data;
         end
      end
      fail_count <= errors;
      pending_count <= due_results.size();
   end

endmodule

// File: tb/sv/imu_fifo_packet_parser_top_tb.sv
// Testbench top: drives FIFO bytes and id writes, stalls the receiver, gives the verdict.
module imu_fifo_packet_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ifpp_pkg::*;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_COMB, RX_BLOCKS} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_ACCEL_ID;
   logic [7:0]  csr_wr_data = '0;
   int          fail_count;
   int          pending_count;

   logic [7:0]  drain_bytes[$];
   logic [7:0]  cur_accel = ACCEL_ID_RESET;
   logic [7:0]  cur_gyro = GYRO_ID_RESET;
   logic [7:0]  phase_accel[8];
   logic [7:0]  phase_gyro[8];
   int          burst_left = 0;
   int          phase_items;
   bit          gaps_on = 1'b1;
   rx_mode_type rx_mode = RX_OPEN;
   logic [6:0]  rx_tick = '0;

   ifpp_req_if req_chan ();
   ifpp_rsp_if rsp_chan ();

   imu_fifo_packet_parser_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   imu_fifo_packet_parser_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // receiver: mode redrawn as rx_tick wraps; blocks stalls while rx_tick[4] is low
   always @(posedge clock) begin
      rx_tick <= rx_tick + 7'd1;
      if (rx_tick == '1) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:   rsp_chan.ready <= 1'b1;
         RX_RANDOM: rsp_chan.ready <= 1'($urandom_range(0, 1));
         RX_COMB:   rsp_chan.ready <= (rx_tick[1:0] != 2'b00);
         default:   rsp_chan.ready <= rx_tick[4];
      endcase
   end

   task automatic send_beat(input logic [7:0] value, input logic last);
      if (burst_left == 0) begin
         if (gaps_on && $urandom_range(0, 2) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= value;
      req_chan.buffer_end <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_drain();
      foreach (drain_bytes[i]) send_beat(drain_bytes[i], i == drain_bytes.size() - 1);
      drain_bytes.delete();
   endtask

   // hold the sender until every predicted result has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_ids(input logic [7:0] accel, input logic [7:0] gyro);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ACCEL_ID;
      csr_wr_data <= accel;
      @(posedge clock);
      csr_index <= CSR_GYRO_ID;
      csr_wr_data <= gyro;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_accel = accel;
      cur_gyro = gyro;
   endtask

   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] unknown_id();
      logic [7:0] v;
      v = 8'($urandom_range(1, 255));
      while (v == cur_accel || v == cur_gyro || (v >= ID_TS_DELTA_S && v <= ID_META_WAKE))
         v = 8'($urandom_range(1, 255));
      return v;
   endfunction

   // appends one whole packet, returns its length with the id byte
   function automatic int add_packet();
      int kind;
      int len;
      logic [7:0] id;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         id = cur_accel;
         len = LEN_SAMPLE;
      end else if (kind < 6) begin
         id = cur_gyro;
         len = LEN_SAMPLE;
      end else if (kind < 8) begin
         id = (kind == 6) ? ID_TS_DELTA_S : ID_TS_DELTA_L;
         len = LEN_DELTA;
      end else begin
         case ($urandom_range(0, 2))
            0:       id = ID_TS_FULL;
            1:       id = ID_META;
            default: id = ID_META_WAKE;
         endcase
         len = LEN_LONG;
      end
      drain_bytes.push_back(id);
      repeat (len) drain_bytes.push_back(payload_byte());
      return len + 1;
   endfunction

   task automatic send_buffer();
      int len;
      int junk;
      int tail;
      junk = 0;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) drain_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 5)) void'(add_packet());
         tail = $urandom_range(0, 9);
         if (tail == 0) begin
            // cut the last packet short, possibly down to its id byte
            len = add_packet();
            repeat ($urandom_range(1, len - 1)) void'(drain_bytes.pop_back());
         end else if (tail < 3) begin
            drain_bytes.push_back((tail == 1) ? ID_PADDING : unknown_id());
            junk = $urandom_range(0, 6);
            repeat (junk) drain_bytes.push_back(8'($urandom_range(0, 255)));
         end
         if (drain_bytes.size() == 0) void'(add_packet());
      end
      phase_items += drain_bytes.size() - junk;
      send_drain();
   endtask

   initial begin
      #5ms;
      $display("imu_fifo_packet_parser_top regression: fail");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.buffer_end = 1'b0;
      phase_accel = '{8'd1, 8'd249, 8'd7, 8'd249, ID_TS_FULL, 8'd0, 8'd0, 8'd0};
      phase_gyro  = '{8'd249, 8'd1, 8'd7, 8'd249, ID_PADDING, 8'd0, 8'd0, 8'd0};
      for (int p = 5; p < 8; p++) begin
         phase_accel[p] = 8'($urandom_range(1, 249));
         phase_gyro[p] = 8'($urandom_range(1, 249));
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // axis extremes, then a gyro sample finished by the buffer's last byte
      drain_bytes = '{ACCEL_ID_RESET, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                      GYRO_ID_RESET, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h03, 8'hFE};
      send_drain();
      // skipped packets, padding, then an ignored byte
      drain_bytes = '{ID_TS_DELTA_L, 8'h11, ID_META, 8'h01, 8'h02, 8'h03, ID_PADDING, 8'h33};
      send_drain();
      drain_bytes = '{8'h77};
      send_drain();
      // id byte as the last byte, and a sample cut short
      drain_bytes = '{GYRO_ID_RESET};
      send_drain();
      drain_bytes = '{ACCEL_ID_RESET, 8'hFF, 8'h00};
      send_drain();

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         write_ids(phase_accel[p], phase_gyro[p]);
         gaps_on = (p % 3) != 2;
         phase_items = 0;
         while (phase_items < 215) begin
            send_buffer();
            if ($urandom_range(0, 14) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("imu_fifo_packet_parser_top regression: pass");
      else
         $display("imu_fifo_packet_parser_top regression: fail");
      $finish;
   end

endmodule
